// File: design/free_fall_detector_defines.svh
// Assertion macros used by the free-fall detector checker.
`ifndef FREE_FALL_DETECTOR_DEFINES_SVH
`define FREE_FALL_DETECTOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FFD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("free_fall_detector: check failed");

// Next-cycle implication, disabled while reset is asserted.
`define FFD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("free_fall_detector: check failed");

`endif

// File: design/ffd_pkg.sv
// Shared constants, types and state encoding of the free-fall detector.
`default_nettype none

package ffd_pkg;

    localparam int DEF_SAMPLE_RATE_HZ = 500;
    localparam int DEF_SAMPLE_WIDTH   = 16;

    // band registers
    localparam int              BAND_W       = 15;
    localparam logic [BAND_W-1:0] CENTER_RESET = 15'd410;
    localparam logic [BAND_W-1:0] TOL_RESET    = 15'd819;
    localparam int              BOUND_W      = BAND_W + 1;

    // APB
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_BAND_CENTER = 1'b0;
    localparam logic REG_BAND_TOL    = 1'b1;

    // run counter and result fields
    localparam int               RUN_W   = 16;
    localparam logic [RUN_W-1:0] RUN_MAX = 16'hFFFF;
    localparam int               MS_W    = 17;
    localparam int               MM_W    = 27;
    localparam int               OUT_PAD_W   = 4;
    localparam int               OUT_TDATA_W = RUN_W + MS_W + MM_W + OUT_PAD_W;

    // scale factors: ms per second, 0.5 * 9.8 m/s^2 in mm/s^2
    localparam int MS_SCALE  = 1000;
    localparam int HALF_G_MM = 4900;
    // 4900 * 65535^2 plus rounding fits in this many bits
    localparam int DIST_NUM_W = 45;
    localparam int DEF_DIV_W  = 18;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ_X,
        ST_SQ_Y,
        ST_SQ_Z,
        ST_SQ_HI,
        ST_SQ_LO,
        ST_CMP,
        ST_MS_MUL,
        ST_MS_DIV,
        ST_MM_MUL1,
        ST_MM_MUL2,
        ST_MM_DIV,
        ST_EMIT
    } ffd_state_t;

    typedef struct packed {
        logic load;
        logic init_acc;
        logic step;
    } ffd_mac_ctl_t;

    typedef struct packed {
        logic load;
        logic step;
    } ffd_div_ctl_t;

endpackage

`default_nettype wire

// File: design/ffd_mac.sv
// Bit-serial shift-and-add multiply-accumulate unit.
`default_nettype none

module ffd_mac #(
    parameter int ACC_W = ffd_pkg::DIST_NUM_W,
    parameter int MUL_W = ffd_pkg::BOUND_W
) (
    input  wire logic                clk,
    input  wire ffd_pkg::ffd_mac_ctl_t ctl,
    input  wire logic [ACC_W-1:0]    mcand_in,
    input  wire logic [MUL_W-1:0]    mplier_in,
    input  wire logic [ACC_W-1:0]    acc_init,
    output logic      [ACC_W-1:0]    acc
);

    logic [ACC_W-1:0] mcand_reg;
    logic [ACC_W-1:0] mcand_next;
    logic [MUL_W-1:0] mplier_reg;
    logic [MUL_W-1:0] mplier_next;
    logic [ACC_W-1:0] acc_reg;
    logic [ACC_W-1:0] acc_next;

    always_comb
    begin
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        acc_next    = acc_reg;
        if (ctl.load)
        begin
            mcand_next  = mcand_in;
            mplier_next = mplier_in;
            if (ctl.init_acc)
            begin
                acc_next = acc_init;
            end
        end
        else if (ctl.step)
        begin
            // one multiplier bit per cycle, LSB first
            if (mplier_reg[0])
            begin
                acc_next = acc_reg + mcand_reg;
            end
            mcand_next  = {mcand_reg[ACC_W-2:0], 1'b0};
            mplier_next = {1'b0, mplier_reg[MUL_W-1:1]};
        end
    end

    always_ff @(posedge clk)
    begin
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        acc_reg    <= acc_next;
    end

    assign acc = acc_reg;

endmodule

`default_nettype wire

// File: design/ffd_div.sv
// Bit-serial restoring divider; keeps the low bits of the quotient.
`default_nettype none

module ffd_div #(
    parameter int NUM_W = ffd_pkg::DIST_NUM_W,
    parameter int DIV_W = ffd_pkg::DEF_DIV_W
) (
    input  wire logic                  clk,
    input  wire ffd_pkg::ffd_div_ctl_t ctl,
    input  wire logic [NUM_W-1:0]      num_in,
    input  wire logic [DIV_W-1:0]      divisor_in,
    output logic [ffd_pkg::MM_W-1:0]   quot
);

    logic [NUM_W-1:0]         num_reg;
    logic [NUM_W-1:0]         num_next;
    logic [DIV_W-1:0]         div_reg;
    logic [DIV_W-1:0]         div_next;
    logic [DIV_W-1:0]         rem_reg;
    logic [DIV_W-1:0]         rem_next;
    logic [ffd_pkg::MM_W-1:0] quot_reg;
    logic [ffd_pkg::MM_W-1:0] quot_next;
    logic [DIV_W:0]           trial;
    logic [DIV_W:0]           diff;
    logic                     ge;

    assign trial = {rem_reg, num_reg[NUM_W-1]};
    assign ge    = (trial >= {1'b0, div_reg});
    assign diff  = trial - {1'b0, div_reg};

    always_comb
    begin
        num_next  = num_reg;
        div_next  = div_reg;
        rem_next  = rem_reg;
        quot_next = quot_reg;
        if (ctl.load)
        begin
            num_next  = num_in;
            div_next  = divisor_in;
            rem_next  = '0;
            quot_next = '0;
        end
        else if (ctl.step)
        begin
            // partial remainder stays below the divisor, so DIV_W bits hold it
            rem_next  = ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
            num_next  = {num_reg[NUM_W-2:0], 1'b0};
            quot_next = {quot_reg[ffd_pkg::MM_W-2:0], ge};
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg  <= num_next;
        div_reg  <= div_next;
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
    end

    assign quot = quot_reg;

endmodule

`default_nettype wire

// File: design/free_fall_detector.sv
// Free-fall detector top level: band test, run counter, fall time and distance.
`default_nettype none

// Takes one three-axis sample per request (x, y, z signed Q4.12 g) and checks
// whether the squared magnitude lies strictly between the squared band bounds
// (center -/+ tolerance, set over APB). In-band samples extend a run that
// saturates at 65535; the first out-of-band sample after a run yields one
// result: run length, duration in ms, and 0.5*9.8*t^2 in mm, both rounded to
// nearest. One request is processed at a time. All products go through one
// bit-serial multiply-accumulate unit and the two quotients through one
// bit-serial divider. A sample that ends a run also computes the result and
// waits, if need be, for the previous result to be taken.
module free_fall_detector #(
    parameter int SAMPLE_RATE_HZ = ffd_pkg::DEF_SAMPLE_RATE_HZ,
    parameter int SAMPLE_WIDTH   = ffd_pkg::DEF_SAMPLE_WIDTH,
    localparam int IN_TDATA_W    = ((3 * SAMPLE_WIDTH + 7) / 8) * 8
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [ffd_pkg::APB_ADDR_W-1:0]     paddr,
    input  wire logic [ffd_pkg::APB_DATA_W-1:0]     pwdata,
    output logic      [ffd_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                    pready,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // accel_x, accel_y, accel_z, zero padding
    input  wire logic [IN_TDATA_W-1:0]              s_axis_tdata,
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // fall_samples, fall_ms, fall_distance_mm, zero padding
    output logic      [ffd_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

    localparam int MUL_W   = (SAMPLE_WIDTH > ffd_pkg::BOUND_W) ? SAMPLE_WIDTH
                                                               : ffd_pkg::BOUND_W;
    localparam int ACC_W   = (2 * SAMPLE_WIDTH > ffd_pkg::DIST_NUM_W) ? 2 * SAMPLE_WIDTH
                                                                      : ffd_pkg::DIST_NUM_W;
    localparam int CNT_W   = $clog2(ACC_W + 1);
    localparam int RATE_SQ = SAMPLE_RATE_HZ * SAMPLE_RATE_HZ;
    localparam int DIV_W   = $clog2(RATE_SQ + 1);
    localparam int HI2_W   = 2 * ffd_pkg::BOUND_W;

    localparam logic [CNT_W-1:0] MUL_LAST  = CNT_W'(MUL_W);
    localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(ACC_W);
    localparam logic [ACC_W-1:0] MS_ROUND  = ACC_W'(SAMPLE_RATE_HZ / 2);
    localparam logic [ACC_W-1:0] MM_ROUND  = ACC_W'(RATE_SQ / 2);
    localparam logic [ACC_W-1:0] MS_FACTOR = ACC_W'(ffd_pkg::MS_SCALE);
    localparam logic [ACC_W-1:0] MM_FACTOR = ACC_W'(ffd_pkg::HALF_G_MM);
    localparam logic [DIV_W-1:0] MS_DIVISOR = DIV_W'(SAMPLE_RATE_HZ);
    localparam logic [DIV_W-1:0] MM_DIVISOR = DIV_W'(RATE_SQ);

    ffd_pkg::ffd_state_t state_reg;
    ffd_pkg::ffd_state_t state_next;

    logic [CNT_W-1:0]                cnt_reg;
    logic [CNT_W-1:0]                cnt_next;
    logic [ffd_pkg::BAND_W-1:0]      center_reg;
    logic [ffd_pkg::BAND_W-1:0]      center_next;
    logic [ffd_pkg::BAND_W-1:0]      tol_reg;
    logic [ffd_pkg::BAND_W-1:0]      tol_next;
    logic [ffd_pkg::RUN_W-1:0]       run_reg;
    logic [ffd_pkg::RUN_W-1:0]       run_next;
    logic                            m_valid_reg;
    logic                            m_valid_next;

    logic [SAMPLE_WIDTH-1:0]         ax_reg;
    logic [SAMPLE_WIDTH-1:0]         ay_reg;
    logic [SAMPLE_WIDTH-1:0]         az_reg;
    logic [ffd_pkg::RUN_W-1:0]       fall_n_reg;
    logic [ACC_W-1:0]                mag2_reg;
    logic [HI2_W-1:0]                hi2_reg;
    logic [ffd_pkg::MS_W-1:0]        ms_reg;
    logic [ffd_pkg::RUN_W-1:0]       out_n_reg;
    logic [ffd_pkg::MS_W-1:0]        out_ms_reg;
    logic [ffd_pkg::MM_W-1:0]        out_mm_reg;

    logic [SAMPLE_WIDTH-1:0]         raw_x;
    logic [SAMPLE_WIDTH-1:0]         raw_y;
    logic [SAMPLE_WIDTH-1:0]         raw_z;
    logic [SAMPLE_WIDTH-1:0]         abs_x;
    logic [SAMPLE_WIDTH-1:0]         abs_y;
    logic [SAMPLE_WIDTH-1:0]         abs_z;
    logic [ffd_pkg::BOUND_W-1:0]     bound_hi;
    logic [ffd_pkg::BAND_W-1:0]      bound_lo;
    logic                            in_band;
    logic                            in_accept;
    logic                            cfg_write;
    logic                            op_state;
    logic                            div_state;
    logic [CNT_W-1:0]                op_last;
    logic                            op_done;

    ffd_pkg::ffd_mac_ctl_t           mac_ctl;
    logic [ACC_W-1:0]                mac_mcand;
    logic [MUL_W-1:0]                mac_mplier;
    logic [ACC_W-1:0]                mac_init;
    logic [ACC_W-1:0]                mac_acc;
    ffd_pkg::ffd_div_ctl_t           div_ctl;
    logic [DIV_W-1:0]                div_divisor;
    logic [ffd_pkg::MM_W-1:0]        div_quot;

    logic                            cap_mag2;
    logic                            cap_hi2;
    logic                            cap_ms;
    logic                            cap_out;

    // ---------------- APB ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        center_next = center_reg;
        tol_next    = tol_reg;
        if (cfg_write)
        begin
            unique case (paddr[ffd_pkg::APB_ADDR_W-1])
                ffd_pkg::REG_BAND_CENTER: center_next = pwdata[ffd_pkg::BAND_W-1:0];
                ffd_pkg::REG_BAND_TOL:    tol_next    = pwdata[ffd_pkg::BAND_W-1:0];
                default:                  center_next = center_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[ffd_pkg::APB_ADDR_W-1])
            ffd_pkg::REG_BAND_CENTER: prdata = ffd_pkg::APB_DATA_W'(center_reg);
            ffd_pkg::REG_BAND_TOL:    prdata = ffd_pkg::APB_DATA_W'(tol_reg);
            default:                  prdata = '0;
        endcase
    end

    // ---------------- input side ----------------
    assign s_axis_tready = (state_reg == ffd_pkg::ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    assign raw_x = s_axis_tdata[SAMPLE_WIDTH-1:0];
    assign raw_y = s_axis_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH];
    assign raw_z = s_axis_tdata[3*SAMPLE_WIDTH-1:2*SAMPLE_WIDTH];
    // the most negative value wraps to 2^(w-1), read as unsigned
    assign abs_x = raw_x[SAMPLE_WIDTH-1] ? (~raw_x + SAMPLE_WIDTH'(1)) : raw_x;
    assign abs_y = raw_y[SAMPLE_WIDTH-1] ? (~raw_y + SAMPLE_WIDTH'(1)) : raw_y;
    assign abs_z = raw_z[SAMPLE_WIDTH-1] ? (~raw_z + SAMPLE_WIDTH'(1)) : raw_z;

    assign bound_hi = {1'b0, center_reg} + {1'b0, tol_reg};
    assign bound_lo = center_reg - tol_reg;

    // in CMP the accumulator still holds lo^2; a negative lower bound is always met
    assign in_band = (mag2_reg < ACC_W'(hi2_reg))
                  && ((tol_reg > center_reg) || (mag2_reg > mac_acc));

    // ---------------- sequencer ----------------
    always_comb
    begin
        op_state  = 1'b0;
        div_state = 1'b0;
        unique case (state_reg)
            ffd_pkg::ST_SQ_X, ffd_pkg::ST_SQ_Y, ffd_pkg::ST_SQ_Z,
            ffd_pkg::ST_SQ_HI, ffd_pkg::ST_SQ_LO, ffd_pkg::ST_MS_MUL,
            ffd_pkg::ST_MM_MUL1, ffd_pkg::ST_MM_MUL2:
                op_state = 1'b1;
            ffd_pkg::ST_MS_DIV, ffd_pkg::ST_MM_DIV:
            begin
                op_state  = 1'b1;
                div_state = 1'b1;
            end
            default:
                op_state = 1'b0;
        endcase
    end

    assign op_last  = div_state ? DIV_LAST : MUL_LAST;
    assign op_done  = op_state && (cnt_reg == op_last);
    assign cnt_next = (op_state && !op_done) ? cnt_reg + CNT_W'(1) : '0;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ffd_pkg::ST_IDLE:
                if (in_accept)
                begin
                    state_next = ffd_pkg::ST_SQ_X;
                end
            ffd_pkg::ST_SQ_X:    if (op_done) state_next = ffd_pkg::ST_SQ_Y;
            ffd_pkg::ST_SQ_Y:    if (op_done) state_next = ffd_pkg::ST_SQ_Z;
            ffd_pkg::ST_SQ_Z:    if (op_done) state_next = ffd_pkg::ST_SQ_HI;
            ffd_pkg::ST_SQ_HI:   if (op_done) state_next = ffd_pkg::ST_SQ_LO;
            ffd_pkg::ST_SQ_LO:   if (op_done) state_next = ffd_pkg::ST_CMP;
            ffd_pkg::ST_CMP:
                if (!in_band && (run_reg != '0))
                begin
                    state_next = ffd_pkg::ST_MS_MUL;
                end
                else
                begin
                    state_next = ffd_pkg::ST_IDLE;
                end
            ffd_pkg::ST_MS_MUL:  if (op_done) state_next = ffd_pkg::ST_MS_DIV;
            ffd_pkg::ST_MS_DIV:  if (op_done) state_next = ffd_pkg::ST_MM_MUL1;
            ffd_pkg::ST_MM_MUL1: if (op_done) state_next = ffd_pkg::ST_MM_MUL2;
            ffd_pkg::ST_MM_MUL2: if (op_done) state_next = ffd_pkg::ST_MM_DIV;
            ffd_pkg::ST_MM_DIV:  if (op_done) state_next = ffd_pkg::ST_EMIT;
            ffd_pkg::ST_EMIT:
                if (!m_valid_reg || m_axis_tready)
                begin
                    state_next = ffd_pkg::ST_IDLE;
                end
            default:
                state_next = ffd_pkg::ST_IDLE;
        endcase
    end

    // datapath controls; each operation loads at count zero, then steps
    always_comb
    begin
        mac_ctl.load     = op_state && !div_state && (cnt_reg == '0);
        mac_ctl.step     = op_state && !div_state && (cnt_reg != '0);
        mac_ctl.init_acc = 1'b1;
        mac_mcand        = '0;
        mac_mplier       = '0;
        mac_init         = '0;
        div_ctl.load     = div_state && (cnt_reg == '0);
        div_ctl.step     = div_state && (cnt_reg != '0);
        div_divisor      = MS_DIVISOR;
        cap_mag2         = 1'b0;
        cap_hi2          = 1'b0;
        cap_ms           = 1'b0;
        cap_out          = 1'b0;
        unique case (state_reg)
            ffd_pkg::ST_SQ_X:
            begin
                mac_mcand  = ACC_W'(ax_reg);
                mac_mplier = MUL_W'(ax_reg);
            end
            ffd_pkg::ST_SQ_Y:
            begin
                mac_mcand        = ACC_W'(ay_reg);
                mac_mplier       = MUL_W'(ay_reg);
                mac_ctl.init_acc = 1'b0;
            end
            ffd_pkg::ST_SQ_Z:
            begin
                mac_mcand        = ACC_W'(az_reg);
                mac_mplier       = MUL_W'(az_reg);
                mac_ctl.init_acc = 1'b0;
            end
            ffd_pkg::ST_SQ_HI:
            begin
                mac_mcand  = ACC_W'(bound_hi);
                mac_mplier = MUL_W'(bound_hi);
                cap_mag2   = mac_ctl.load;
            end
            ffd_pkg::ST_SQ_LO:
            begin
                mac_mcand  = ACC_W'(bound_lo);
                mac_mplier = MUL_W'(bound_lo);
                cap_hi2    = mac_ctl.load;
            end
            ffd_pkg::ST_MS_MUL:
            begin
                mac_mcand  = MS_FACTOR;
                mac_mplier = MUL_W'(fall_n_reg);
                mac_init   = MS_ROUND;
            end
            ffd_pkg::ST_MS_DIV:
                div_divisor = MS_DIVISOR;
            ffd_pkg::ST_MM_MUL1:
            begin
                mac_mcand  = MM_FACTOR;
                mac_mplier = MUL_W'(fall_n_reg);
                cap_ms     = mac_ctl.load;
            end
            ffd_pkg::ST_MM_MUL2:
            begin
                mac_mcand  = mac_acc;
                mac_mplier = MUL_W'(fall_n_reg);
                mac_init   = MM_ROUND;
            end
            ffd_pkg::ST_MM_DIV:
                div_divisor = MM_DIVISOR;
            ffd_pkg::ST_EMIT:
                cap_out = !m_valid_reg || m_axis_tready;
            default:
                mac_ctl.init_acc = 1'b1;
        endcase
    end

    always_comb
    begin
        run_next = run_reg;
        if (state_reg == ffd_pkg::ST_CMP)
        begin
            priority if (in_band)
            begin
                if (run_reg != ffd_pkg::RUN_MAX)
                begin
                    run_next = run_reg + ffd_pkg::RUN_W'(1);
                end
            end
            else
            begin
                run_next = '0;
            end
        end
    end

    always_comb
    begin
        m_valid_next = m_valid_reg && !m_axis_tready;
        if (cap_out)
        begin
            m_valid_next = 1'b1;
        end
    end

    ffd_mac #(
        .ACC_W(ACC_W),
        .MUL_W(MUL_W)
    ) u_ffd_mac (
        .clk      (clk),
        .ctl      (mac_ctl),
        .mcand_in (mac_mcand),
        .mplier_in(mac_mplier),
        .acc_init (mac_init),
        .acc      (mac_acc)
    );

    ffd_div #(
        .NUM_W(ACC_W),
        .DIV_W(DIV_W)
    ) u_ffd_div (
        .clk       (clk),
        .ctl       (div_ctl),
        .num_in    (mac_acc),
        .divisor_in(div_divisor),
        .quot      (div_quot)
    );

    // ---------------- registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ffd_pkg::ST_IDLE;
            cnt_reg     <= '0;
            center_reg  <= ffd_pkg::CENTER_RESET;
            tol_reg     <= ffd_pkg::TOL_RESET;
            run_reg     <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            center_reg  <= center_next;
            tol_reg     <= tol_next;
            run_reg     <= run_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            ax_reg <= abs_x;
            ay_reg <= abs_y;
            az_reg <= abs_z;
        end
        if (cap_mag2)
        begin
            mag2_reg <= mac_acc;
        end
        if (cap_hi2)
        begin
            hi2_reg <= mac_acc[HI2_W-1:0];
        end
        if (state_reg == ffd_pkg::ST_CMP)
        begin
            fall_n_reg <= run_reg;
        end
        if (cap_ms)
        begin
            ms_reg <= div_quot[ffd_pkg::MS_W-1:0];
        end
        if (cap_out)
        begin
            out_n_reg  <= fall_n_reg;
            out_ms_reg <= ms_reg;
            out_mm_reg <= div_quot;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {{ffd_pkg::OUT_PAD_W{1'b0}}, out_mm_reg, out_ms_reg, out_n_reg};

endmodule

`default_nettype wire

// File: design/ffd_checker.sv
// Port-level checker for the free-fall detector, bound to the top level.
`default_nettype none
`include "free_fall_detector_defines.svh"

module ffd_checker (
    input wire logic                            clk,
    input wire logic                            rst_n,
    input wire logic                            s_axis_tvalid,
    input wire logic                            s_axis_tready,
    input wire logic                            m_axis_tvalid,
    input wire logic                            m_axis_tready,
    input wire logic [ffd_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    // one request in flight: ready drops right after an accept
    `FFD_ASSERT_NEXT(a_one_in_flight, clk, rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)

    // a new result only appears while a request is being worked on
    `FFD_ASSERT_NOW(a_result_from_work, clk, rst_n, $rose(m_axis_tvalid), $past(!s_axis_tready))

    // a reported run is never empty
    `FFD_ASSERT_NOW(a_run_nonzero, clk, rst_n, m_axis_tvalid,
        m_axis_tdata[ffd_pkg::RUN_W-1:0] != '0)

    `FFD_ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata))

endmodule

bind free_fall_detector ffd_checker u_ffd_checker (.*);

`default_nettype wire
